/* src/etwc_pkg.sv */
`default_nettype none
// Shared types and codes of the edge-triggered window capture block.
// Used by the controller, the slot datapath and the top level; no dependencies.
package etwc_pkg;

  // Request kinds carried on req_type.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_IMM  = 2'd1;
  localparam logic [1:0] REQ_RISE = 2'd2;
  localparam logic [1:0] REQ_FALL = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT  = 2'd1;
  localparam logic [1:0] STAT_ZERO_LEN = 2'd2;

  // Result kinds.
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_WINDOW = 1'b1;

  // Fixed field widths.
  localparam int LEN_W    = 7;
  localparam int BITS_W   = 64;
  localparam int SLOTID_W = 3;

  // Mode of a capture slot.
  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_RISE    = 2'd2,
    MODE_FALL    = 2'd3
  } slot_mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req;   // claim a slot for the request on the input ports
    logic tick;  // take a sample on every capturing slot
    logic scan;  // visit the queue position given on the scan rank
    logic last;  // a window emitted now is the last of its tick
  } etwc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;   // a filled window sits at the scanned queue position
  } etwc_stat_t;

endpackage
`default_nettype wire

/* src/etwc_ctrl.sv */
`default_nettype none
// Controller of the capture block: accepts requests and sequences the
// emission scan over queue positions. Depends on etwc_pkg.
module etwc_ctrl import etwc_pkg::*; #(
  parameter int SLOTS = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [1:0]                      req_type_i,
  output logic                                 busy_o,
  output etwc_cmd_t                            cmd_o,
  input  wire etwc_stat_t                      stat_i,
  input  wire logic [$clog2(SLOTS+1)-1:0]      done_cnt_i,
  output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] scan_rank_o,
  output logic [$clog2(SLOTS+1)-1:0]           emit_cnt_o
);

  localparam int RANK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_q, state_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [CNT_W-1:0]  emit_q, emit_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic              accept;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q == S_SCAN);
  assign scan_rank_o = rank_q;
  assign emit_cnt_o  = emit_q;

  // Command decode and scan sequencing.
  always_comb begin
    state_d       = state_q;
    rank_d        = rank_q;
    emit_d        = emit_q;
    total_d       = total_q;
    cmd_o.req     = 1'b0;
    cmd_o.tick    = 1'b0;
    cmd_o.scan    = 1'b0;
    cmd_o.last    = (emit_q + CNT_W'(1)) == total_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_TICK) begin
            cmd_o.tick = 1'b1;
            total_d    = done_cnt_i;
            rank_d     = '0;
            emit_d     = '0;
            if (done_cnt_i != '0) begin
              state_d = S_SCAN;
            end
          end else begin
            cmd_o.req = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          emit_d = emit_q + CNT_W'(1);
        end
        if (rank_q == RANK_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          rank_d = rank_q + RANK_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rank_q  <= '0;
      emit_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
      emit_q  <= emit_d;
      total_q <= total_d;
    end
  end

endmodule
`default_nettype wire

/* src/etwc_datapath.sv */
`default_nettype none
// Slot datapath of the capture block: slot state, sampling, claims and the
// result registers. Depends on etwc_pkg; driven by etwc_ctrl.
module etwc_datapath import etwc_pkg::*; #(
  parameter int SLOTS       = 8,
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire etwc_cmd_t                             cmd_i,
  output etwc_stat_t                                 stat_o,
  input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] scan_rank_i,
  input  wire logic [$clog2(SLOTS+1)-1:0]            emit_cnt_i,
  output logic [$clog2(SLOTS+1)-1:0]                 done_cnt_o,
  input  wire logic [1:0]                            req_type_i,
  input  wire logic                                  sample_level_i,
  input  wire logic [LEN_W-1:0]                      window_length_i,
  output logic                                       result_strobe_o,
  output logic                                       result_kind_o,
  output logic [1:0]                                 status_o,
  output logic [SLOTID_W-1:0]                        slot_id_o,
  output logic [BITS_W-1:0]                          captured_bits_o,
  output logic [LEN_W-1:0]                           captured_count_o,
  output logic                                       last_o
);

  localparam int RANK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  slot_mode_e               mode_q   [SLOTS];
  slot_mode_e               mode_d   [SLOTS];
  logic [RANK_W-1:0]        rank_q   [SLOTS];
  logic [RANK_W-1:0]        rank_d   [SLOTS];
  logic [LEN_W-1:0]         fill_q   [SLOTS];
  logic [LEN_W-1:0]         fill_d   [SLOTS];
  logic [LEN_W-1:0]         target_q [SLOTS];
  logic [LEN_W-1:0]         target_d [SLOTS];
  logic [MAX_SAMPLES-1:0]   samp_q   [SLOTS];
  logic [MAX_SAMPLES-1:0]   samp_d   [SLOTS];
  logic [SLOTS-1:0]         done_q, done_d;
  logic                     prev_q, prev_d;

  logic                     strobe_q, strobe_d;
  logic                     kind_q, kind_d;
  logic [1:0]               status_q, status_d;
  logic [SLOTID_W-1:0]      slot_id_q, slot_id_d;
  logic [BITS_W-1:0]        bits_q, bits_d;
  logic [LEN_W-1:0]         count_q, count_d;
  logic                     last_q, last_d;

  logic                     rise, fall;
  logic [CNT_W-1:0]         cap_cnt;
  logic [SLOTS-1:0]         act_vec, cap_vec, tick_done;
  logic [CNT_W-1:0]         tick_done_cnt;
  slot_mode_e               req_mode;
  logic [CNT_W-1:0]         req_mode_cnt;
  logic                     free_found;
  logic [IDX_W-1:0]         free_idx;
  logic [LEN_W-1:0]         sat_len;
  logic [SLOTS-1:0]         scan_match, scan_hit;
  logic [IDX_W-1:0]         hit_idx;

  // Edge detection and the size of the capture queue before activation.
  assign rise = sample_level_i && !prev_q;
  assign fall = !sample_level_i && prev_q;

  always_comb begin
    cap_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cap_cnt = cap_cnt + CNT_W'(mode_q[i] == MODE_CAPTURE);
    end
  end

  // Which slots activate and which capture on a tick, and which fill.
  always_comb begin
    tick_done_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      act_vec[i]   = (rise && mode_q[i] == MODE_RISE) || (fall && mode_q[i] == MODE_FALL);
      cap_vec[i]   = (mode_q[i] == MODE_CAPTURE) || act_vec[i];
      tick_done[i] = cap_vec[i] && ((fill_q[i] + LEN_W'(1)) >= target_q[i]);
      tick_done_cnt = tick_done_cnt + CNT_W'(tick_done[i]);
    end
  end

  assign done_cnt_o = tick_done_cnt;

  // Mode requested, its queue length, the lowest free slot and the length.
  always_comb begin
    unique case (req_type_i)
      REQ_RISE: req_mode = MODE_RISE;
      REQ_FALL: req_mode = MODE_FALL;
      default:  req_mode = MODE_CAPTURE;
    endcase
  end

  always_comb begin
    req_mode_cnt = '0;
    free_found   = 1'b0;
    free_idx     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      req_mode_cnt = req_mode_cnt + CNT_W'(mode_q[i] == req_mode);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mode_q[i] == MODE_FREE) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign sat_len = (window_length_i > LEN_W'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES)
                                                           : window_length_i;

  // The filled slot, if any, at the queue position being scanned.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      scan_match[i] = (mode_q[i] == MODE_CAPTURE) && (rank_q[i] == scan_rank_i);
      scan_hit[i]   = scan_match[i] && done_q[i];
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (scan_hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign stat_o.hit = |scan_hit;

  // Next state of the slots and of the result registers.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      mode_d[i]   = mode_q[i];
      rank_d[i]   = rank_q[i];
      fill_d[i]   = fill_q[i];
      target_d[i] = target_q[i];
      samp_d[i]   = samp_q[i];
    end
    done_d    = done_q;
    prev_d    = prev_q;
    strobe_d  = 1'b0;
    kind_d    = kind_q;
    status_d  = status_q;
    slot_id_d = slot_id_q;
    bits_d    = bits_q;
    count_d   = count_q;
    last_d    = last_q;

    // A sample tick activates armed slots and appends to every capturing one.
    if (cmd_i.tick) begin
      prev_d = sample_level_i;
      done_d = tick_done;
      for (int i = 0; i < SLOTS; i++) begin
        if (act_vec[i]) begin
          mode_d[i] = MODE_CAPTURE;
          rank_d[i] = rank_q[i] + RANK_W'(cap_cnt);
        end
        if (cap_vec[i]) begin
          fill_d[i] = fill_q[i] + LEN_W'(1);
          for (int b = 0; b < MAX_SAMPLES; b++) begin
            if (fill_q[i] == LEN_W'(b)) begin
              samp_d[i][b] = sample_level_i;
            end
          end
        end
      end
    end

    // A window request claims the lowest free slot at the tail of its queue.
    if (cmd_i.req) begin
      strobe_d  = 1'b1;
      kind_d    = KIND_ACK;
      slot_id_d = '0;
      bits_d    = '0;
      count_d   = '0;
      last_d    = 1'b1;
      if (window_length_i == '0) begin
        status_d = STAT_ZERO_LEN;
      end else if (!free_found) begin
        status_d = STAT_NO_SLOT;
      end else begin
        status_d           = STAT_OK;
        slot_id_d          = SLOTID_W'(free_idx);
        mode_d[free_idx]   = req_mode;
        rank_d[free_idx]   = RANK_W'(req_mode_cnt);
        target_d[free_idx] = sat_len;
        fill_d[free_idx]   = '0;
        samp_d[free_idx]   = '0;
        done_d[free_idx]   = 1'b0;
      end
    end

    // The scan emits a filled window or closes up the slot's queue position.
    if (cmd_i.scan) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (scan_match[i]) begin
          if (done_q[i]) begin
            mode_d[i] = MODE_FREE;
            rank_d[i] = '0;
            fill_d[i] = '0;
            done_d[i] = 1'b0;
          end else begin
            rank_d[i] = scan_rank_i - RANK_W'(emit_cnt_i);
          end
        end
      end
      if (|scan_hit) begin
        strobe_d  = 1'b1;
        kind_d    = KIND_WINDOW;
        status_d  = STAT_OK;
        slot_id_d = SLOTID_W'(hit_idx);
        bits_d    = BITS_W'(samp_q[hit_idx]);
        count_d   = target_q[hit_idx];
        last_d    = cmd_i.last;
      end
    end
  end

  // Slot control state and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        mode_q[i]   <= MODE_FREE;
        rank_q[i]   <= '0;
        fill_q[i]   <= '0;
        target_q[i] <= '0;
      end
      done_q   <= '0;
      prev_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      for (int i = 0; i < SLOTS; i++) begin
        mode_q[i]   <= mode_d[i];
        rank_q[i]   <= rank_d[i];
        fill_q[i]   <= fill_d[i];
        target_q[i] <= target_d[i];
      end
      done_q   <= done_d;
      prev_q   <= prev_d;
      strobe_q <= strobe_d;
    end
  end

  // Sample store and result payload.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      samp_q[i] <= samp_d[i];
    end
    kind_q    <= kind_d;
    status_q  <= status_d;
    slot_id_q <= slot_id_d;
    bits_q    <= bits_d;
    count_q   <= count_d;
    last_q    <= last_d;
  end

  assign result_strobe_o  = strobe_q;
  assign result_kind_o    = kind_q;
  assign status_o         = status_q;
  assign slot_id_o        = slot_id_q;
  assign captured_bits_o  = bits_q;
  assign captured_count_o = count_q;
  assign last_o           = last_q;

endmodule
`default_nettype wire

/* src/edge_triggered_window_capture.sv */
`default_nettype none
// Multi-slot edge-triggered window capture unit: top level.
// Depends on etwc_pkg, etwc_ctrl and etwc_datapath.
//
// A window request (immediate, armed on a rising edge or armed on a falling
// edge) is answered by a single acknowledgement in the cycle after it is
// taken; busy stays low, so requests may follow back to back. A sample tick
// updates every slot at once. If no window fills, the block is free again
// in the next cycle. If windows fill, the controller scans every position
// of the capture queue, one position per cycle, with busy high during the
// scan. Filled windows come out in activation order, at most one per cycle,
// each marked by result_strobe_o for a single cycle; the receiver cannot
// hold them off and must take every result as it appears.
module edge_triggered_window_capture import etwc_pkg::*; #(
  parameter int SLOTS       = 8,
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           req_type_i,
  input  wire logic                 sample_level_i,
  input  wire logic [LEN_W-1:0]     window_length_i,
  output logic                      result_strobe_o,
  output logic                      result_kind_o,
  output logic [1:0]                status_o,
  output logic [SLOTID_W-1:0]       slot_id_o,
  output logic [BITS_W-1:0]         captured_bits_o,
  output logic [LEN_W-1:0]          captured_count_o,
  output logic                      last_o
);

  localparam int RANK_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  etwc_cmd_t         cmd;
  etwc_stat_t        stat;
  logic [RANK_W-1:0] scan_rank;
  logic [CNT_W-1:0]  emit_cnt;
  logic [CNT_W-1:0]  done_cnt;

  // Request sequencing.
  etwc_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_type_i  (req_type_i),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .done_cnt_i  (done_cnt),
    .scan_rank_o (scan_rank),
    .emit_cnt_o  (emit_cnt)
  );

  // Slot state and results.
  etwc_datapath #(
    .SLOTS       (SLOTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .scan_rank_i      (scan_rank),
    .emit_cnt_i       (emit_cnt),
    .done_cnt_o       (done_cnt),
    .req_type_i       (req_type_i),
    .sample_level_i   (sample_level_i),
    .window_length_i  (window_length_i),
    .result_strobe_o  (result_strobe_o),
    .result_kind_o    (result_kind_o),
    .status_o         (status_o),
    .slot_id_o        (slot_id_o),
    .captured_bits_o  (captured_bits_o),
    .captured_count_o (captured_count_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

/* test/edge_triggered_window_capture_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the edge-triggered window capture block.
// Needs etwc_pkg and edge_triggered_window_capture; predicts every result itself.
module edge_triggered_window_capture_tb;
  import etwc_pkg::*;

  localparam int SLOTS       = 8;
  localparam int MAX_SAMPLES = 64;
  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_GAP     = 40;

  // One result as it appears on the result ports.
  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [2:0]       slot;
    logic [BITS_W-1:0] bits;
    logic [LEN_W-1:0] count;
    logic             last;
  } capture_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [1:0]          req_type_i;
  logic                sample_level_i;
  logic [LEN_W-1:0]    window_length_i;
  logic                result_strobe_o;
  logic                result_kind_o;
  logic [1:0]          status_o;
  logic [SLOTID_W-1:0] slot_id_o;
  logic [BITS_W-1:0]   captured_bits_o;
  logic [LEN_W-1:0]    captured_count_o;
  logic                last_o;

  // Predicted slot state, kept in step with every accepted request.
  slot_mode_e          mode_q    [SLOTS];
  logic [7:0]          target_q  [SLOTS];
  logic [7:0]          fill_q    [SLOTS];
  logic [BITS_W-1:0]   samples_q [SLOTS];
  logic [7:0]          rank_q    [SLOTS];
  logic                level_q;

  capture_result_t     outstanding_results[$];
  capture_result_t     due;
  int                  sender_idle_pct = 0;
  int                  errors          = 0;
  int                  cycle_count     = 0;
  int                  ticks_sent      = 0;
  int                  claims_sent     = 0;
  int                  acks_checked    = 0;
  int                  windows_checked = 0;

  edge_triggered_window_capture #(
    .SLOTS       (SLOTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .sample_level_i   (sample_level_i),
    .window_length_i  (window_length_i),
    .result_strobe_o  (result_strobe_o),
    .result_kind_o    (result_kind_o),
    .status_o         (status_o),
    .slot_id_o        (slot_id_o),
    .captured_bits_o  (captured_bits_o),
    .captured_count_o (captured_count_o),
    .last_o           (last_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic capture_result_t make_result(input logic kind, input logic [1:0] status,
                                                  input logic [2:0] slot,
                                                  input logic [BITS_W-1:0] bits,
                                                  input logic [LEN_W-1:0] count,
                                                  input logic last);
    capture_result_t r;
    r.kind   = kind;
    r.status = status;
    r.slot   = slot;
    r.bits   = bits;
    r.count  = count;
    r.last   = last;
    return r;
  endfunction

  // Appends one predicted result to the tail of the pending list.
  function automatic void enqueue_result(input capture_result_t r);
    outstanding_results.insert(outstanding_results.size(), r);
  endfunction

  function automatic int count_in_mode(input slot_mode_e m);
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (mode_q[i] == m) n++;
    end
    return n;
  endfunction

  // Armed slots join the tail of the capture queue, keeping their own order.
  function automatic void activate_armed(input slot_mode_e m);
    int base;
    base = count_in_mode(MODE_CAPTURE);
    for (int i = 0; i < SLOTS; i++) begin
      if (mode_q[i] == m) begin
        mode_q[i] = MODE_CAPTURE;
        rank_q[i] = rank_q[i] + 8'(base);
      end
    end
  endfunction

  // Works out the results of one accepted request and queues them in order.
  task automatic capture_unit_step(input logic [1:0] kind_in, input logic lvl,
                                   input logic [LEN_W-1:0] len_in);
    bit         done     [SLOTS];
    logic [7:0] new_rank [SLOTS];
    int         total;
    int         emitted;
    int         c;
    int         free_slot;
    int         len;
    slot_mode_e m;
    if (kind_in == REQ_TICK) begin
      if (lvl && !level_q) activate_armed(MODE_RISE);
      else if (!lvl && level_q) activate_armed(MODE_FALL);
      level_q = lvl;

      // Every capturing slot takes the sample, including those just activated.
      total = 0;
      for (int i = 0; i < SLOTS; i++) begin
        done[i] = 1'b0;
        if (mode_q[i] == MODE_CAPTURE) begin
          if (fill_q[i] < 8'd64) samples_q[i] = samples_q[i] | (64'(lvl) << fill_q[i]);
          fill_q[i] = fill_q[i] + 8'd1;
          done[i]   = (fill_q[i] >= target_q[i]);
          if (done[i] && rank_q[i] < 8'(SLOTS)) total++;
        end
      end

      // Filled windows leave in capture-queue order.
      emitted = 0;
      for (int rk = 0; rk < SLOTS; rk++) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (mode_q[i] == MODE_CAPTURE && rank_q[i] == 8'(rk) && done[i]) begin
            enqueue_result(make_result(KIND_WINDOW, STAT_OK, 3'(i), samples_q[i],
                                       LEN_W'(target_q[i]), emitted == total - 1));
            emitted++;
          end
        end
      end

      // Close up the queue behind the slots that have left it.
      for (int i = 0; i < SLOTS; i++) begin
        new_rank[i] = rank_q[i];
        if (mode_q[i] == MODE_CAPTURE && !done[i]) begin
          c = 0;
          for (int j = 0; j < SLOTS; j++) begin
            if (mode_q[j] == MODE_CAPTURE && !done[j] && rank_q[j] < rank_q[i]) c++;
          end
          new_rank[i] = 8'(c);
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (mode_q[i] == MODE_CAPTURE && done[i]) begin
          mode_q[i] = MODE_FREE;
          rank_q[i] = 8'd0;
          fill_q[i] = 8'd0;
        end else begin
          rank_q[i] = new_rank[i];
        end
      end
      ticks_sent++;
    end else begin
      claims_sent++;
      if (len_in == '0) begin
        enqueue_result(make_result(KIND_ACK, STAT_ZERO_LEN, 3'd0, '0, '0, 1'b1));
      end else begin
        len = (len_in > MAX_SAMPLES) ? MAX_SAMPLES : int'(len_in);
        free_slot = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (mode_q[i] == MODE_FREE) free_slot = i;
        end
        if (free_slot >= SLOTS) begin
          enqueue_result(make_result(KIND_ACK, STAT_NO_SLOT, 3'd0, '0, '0, 1'b1));
        end else begin
          if (kind_in == REQ_IMM) m = MODE_CAPTURE;
          else if (kind_in == REQ_RISE) m = MODE_RISE;
          else m = MODE_FALL;
          rank_q[free_slot]    = 8'(count_in_mode(m));
          mode_q[free_slot]    = m;
          target_q[free_slot]  = 8'(len);
          fill_q[free_slot]    = 8'd0;
          samples_q[free_slot] = '0;
          enqueue_result(make_result(KIND_ACK, STAT_OK, 3'(free_slot), '0, '0, 1'b1));
        end
      end
    end
  endtask

  // Sends one request after a random pause and records its predicted results.
  task automatic send_item(input logic [1:0] kind, input logic lvl,
                           input logic [LEN_W-1:0] len);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    req_type_i      <= kind;
    sample_level_i  <= lvl;
    window_length_i <= len;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    capture_unit_step(kind, lvl, len);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Every strobed result is taken at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (outstanding_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, kind %0d slot %0d", $time,
                 result_kind_o, slot_id_o);
      end else begin
        due = outstanding_results.pop_front();
        compare_field("result_kind", 64'(due.kind), 64'(result_kind_o));
        compare_field("status", 64'(due.status), 64'(status_o));
        compare_field("slot_id", 64'(due.slot), 64'(slot_id_o));
        compare_field("captured_bits", due.bits, captured_bits_o);
        compare_field("captured_count", 64'(due.count), 64'(captured_count_o));
        compare_field("last", 64'(due.last), 64'(last_o));
        if (due.kind == KIND_WINDOW) windows_checked++;
        else acks_checked++;
      end
    end
  end

  // Zero-length requests are refused before any slot is looked at.
  task automatic test_zero_length;
    send_item(REQ_IMM, 1'b1, 7'd0);
    send_item(REQ_FALL, 1'b0, 7'd0);
    send_item(REQ_TICK, 1'b0, 7'd127);
  endtask

  // Armed windows take the edge sample first; immediate ones start next tick.
  task automatic test_edge_arming;
    send_item(REQ_RISE, 1'b0, 7'd2);
    send_item(REQ_FALL, 1'b1, 7'd1);
    send_item(REQ_IMM, 1'b0, 7'd1);
    send_item(REQ_TICK, 1'b1, 7'd0);
    send_item(REQ_TICK, 1'b0, 7'd64);
  endtask

  // All slots taken, long lengths saturating on the way, then one more refused.
  task automatic test_slot_exhaustion;
    send_item(REQ_IMM, 1'b0, 7'd1);
    send_item(REQ_RISE, 1'b1, 7'd1);
    send_item(REQ_FALL, 1'b0, 7'd64);
    send_item(REQ_IMM, 1'b1, 7'd127);
    send_item(REQ_IMM, 1'b0, 7'd65);
    send_item(REQ_RISE, 1'b1, 7'd2);
    send_item(REQ_IMM, 1'b0, 7'd1);
    send_item(REQ_IMM, 1'b1, 7'd3);
    send_item(REQ_IMM, 1'b0, 7'd5);
    send_item(REQ_TICK, 1'b1, 7'd0);
    send_item(REQ_TICK, 1'b0, 7'd0);
    send_item(REQ_TICK, 1'b1, 7'd0);
  endtask

  // Mixed traffic: mostly ticks and short windows, some long and some refused.
  task automatic test_random_traffic(input int idle_pct, input int count);
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    int               pick;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        kind = REQ_TICK;
        len  = LEN_W'($urandom_range(127));
      end else begin
        kind = 2'($urandom_range(3, 1));
        pick = $urandom_range(99);
        if (pick < 8) len = '0;
        else if (pick < 80) len = LEN_W'($urandom_range(8, 1));
        else if (pick < 93) len = LEN_W'($urandom_range(64, 9));
        else len = LEN_W'($urandom_range(127, 65));
      end
      send_item(kind, 1'($urandom_range(1)), len);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      mode_q[i]    = MODE_FREE;
      target_q[i]  = 8'd0;
      fill_q[i]    = 8'd0;
      samples_q[i] = '0;
      rank_q[i]    = 8'd0;
    end
    level_q         = 1'b0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    req_type_i      = REQ_TICK;
    sample_level_i  = 1'b0;
    window_length_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_length;
    test_edge_arming;
    test_slot_exhaustion;
    test_random_traffic(0, 44);
    test_random_traffic(74, 44);
    test_random_traffic(25, 44);

    // Drain: wait for every outstanding result, then allow a full scan more.
    start_i <= 1'b0;
    while (outstanding_results.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 4) @(posedge clk_i);

    $display("Sent %0d sample ticks and %0d window requests over three pacing phases.",
             ticks_sent, claims_sent);
    $display("Checked %0d acknowledgements and %0d filled windows; %0d mismatches.",
             acks_checked, windows_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/etwc_pkg.sv
src/etwc_ctrl.sv
src/etwc_datapath.sv
src/edge_triggered_window_capture.sv
test/edge_triggered_window_capture_tb.sv
